// ===== hdl/lpcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_pkg: shared types and codes for the command deframer
// Phase codes of the frame parser and the record kind codes.
// ----------------------------------------------------------------------------
package lpcd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 32;

	// Record kinds on the output channel
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// Frame parser phase, one-hot
	typedef enum logic [5:0] {
		PH_CMD  = 6'b000001,
		PH_LEN1 = 6'b000010,
		PH_LEN2 = 6'b000100,
		PH_LEN3 = 6'b001000,
		PH_LEN4 = 6'b010000,
		PH_DATA = 6'b100000
	} phase_t;

endpackage

// ===== hdl/lpcd_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_byte_if: raw stream channel
// One stream byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpcd_byte_if;
	logic                       valid;
	logic                       ready;
	logic [lpcd_pkg::BYTE_W-1:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

// ===== hdl/lpcd_record_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_record_if: deframed record channel
// Header and payload records, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpcd_record_if;
	logic                       valid;
	logic                       ready;
	logic                       record_kind;
	logic [lpcd_pkg::BYTE_W-1:0] command_code;
	logic [lpcd_pkg::LEN_W-1:0]  frame_length;
	logic [lpcd_pkg::BYTE_W-1:0] payload_byte;
	logic                       frame_last;

	modport source (output valid, output record_kind, output command_code,
		output frame_length, output payload_byte, output frame_last, input ready);
	modport sink   (input valid, input record_kind, input command_code,
		input frame_length, input payload_byte, input frame_last, output ready);
endinterface

// ===== hdl/length_prefixed_command_deframer.sv =====
`timescale 1ns / 1ps
// Pipeline: a byte is registered in the input stage at acceptance; its record
//   is then registered in the result register.
// Throughput: one stream byte per cycle; each byte only steps the phase and
//   the remaining-byte counter, so nothing limits the rate but output stall.
// Reset: arst_n clears the phase to expect-command and empties both stages.
// ----------------------------------------------------------------------------
// length_prefixed_command_deframer: byte stream to header/payload records
// Parses frames of command byte, 32-bit big-endian length and payload bytes.
// Emits a header record after the fourth length byte, then one record per
// payload byte; the final record of each frame is marked last.
// ----------------------------------------------------------------------------
module length_prefixed_command_deframer (
	input  logic                 clk,
	input  logic                 arst_n,
	lpcd_byte_if.sink            stream,
	lpcd_record_if.source        record
);

	// Input stage
	logic                        valid_s1;
	logic [lpcd_pkg::BYTE_W-1:0] byte_s1;

	// Frame state
	lpcd_pkg::phase_t            phase_q, phase_d;
	logic [lpcd_pkg::BYTE_W-1:0] command_q, command_d;
	logic [lpcd_pkg::LEN_W-1:0]  length_q, length_d;
	logic [lpcd_pkg::LEN_W-1:0]  remain_q, remain_d;

	// Result register
	logic                        res_valid_q;
	logic                        res_kind_q;
	logic [lpcd_pkg::BYTE_W-1:0] res_command_q;
	logic [lpcd_pkg::LEN_W-1:0]  res_length_q;
	logic [lpcd_pkg::BYTE_W-1:0] res_payload_q;
	logic                        res_last_q;

	// Next result
	logic                        emit_d;
	logic                        kind_d;
	logic [lpcd_pkg::BYTE_W-1:0] payload_d;
	logic                        last_d;
	logic [lpcd_pkg::LEN_W-1:0]  full_len;

	logic adv;
	logic fire;

	// The pipeline moves whenever the result slot is free or being drained
	assign adv          = !res_valid_q || record.ready;
	assign fire         = valid_s1 && adv;
	assign stream.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.stream_byte;
		end
	end

	// Length with the low byte merged in on the last header byte
	assign full_len = {length_q[lpcd_pkg::LEN_W-1:lpcd_pkg::BYTE_W], byte_s1};

	// Frame parser
	always_comb begin
		phase_d   = phase_q;
		command_d = command_q;
		length_d  = length_q;
		remain_d  = remain_q;
		emit_d    = 1'b0;
		kind_d    = lpcd_pkg::KIND_HEADER;
		payload_d = '0;
		last_d    = 1'b0;
		case (phase_q)
			lpcd_pkg::PH_LEN1: begin
				length_d[31:24] = byte_s1;
				phase_d         = lpcd_pkg::PH_LEN2;
			end
			lpcd_pkg::PH_LEN2: begin
				length_d[23:16] = byte_s1;
				phase_d         = lpcd_pkg::PH_LEN3;
			end
			lpcd_pkg::PH_LEN3: begin
				length_d[15:8] = byte_s1;
				phase_d        = lpcd_pkg::PH_LEN4;
			end
			lpcd_pkg::PH_LEN4: begin
				length_d = full_len;
				remain_d = full_len;
				emit_d   = 1'b1;
				if (full_len == '0) begin
					last_d  = 1'b1;
					phase_d = lpcd_pkg::PH_CMD;
				end else begin
					phase_d = lpcd_pkg::PH_DATA;
				end
			end
			lpcd_pkg::PH_DATA: begin
				// Count down what is left; length is nonzero in this phase
				remain_d  = remain_q - {{(lpcd_pkg::LEN_W-1){1'b0}}, 1'b1};
				emit_d    = 1'b1;
				kind_d    = lpcd_pkg::KIND_PAYLOAD;
				payload_d = byte_s1;
				if (remain_q == {{(lpcd_pkg::LEN_W-1){1'b0}}, 1'b1}) begin
					last_d  = 1'b1;
					phase_d = lpcd_pkg::PH_CMD;
				end
			end
			default: begin
				command_d = byte_s1;
				length_d  = '0;
				remain_d  = '0;
				phase_d   = lpcd_pkg::PH_LEN1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lpcd_pkg::PH_CMD;
			command_q <= '0;
			length_q  <= '0;
			remain_q  <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			command_q <= command_d;
			length_q  <= length_d;
			remain_q  <= remain_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= fire && emit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit_d) begin
			res_kind_q    <= kind_d;
			res_command_q <= command_d;
			res_length_q  <= length_d;
			res_payload_q <= payload_d;
			res_last_q    <= last_d;
		end
	end

	assign record.valid        = res_valid_q;
	assign record.record_kind  = res_kind_q;
	assign record.command_code = res_command_q;
	assign record.frame_length = res_length_q;
	assign record.payload_byte = res_payload_q;
	assign record.frame_last   = res_last_q;

	// A header of a nonempty frame leaves the parser in the data phase
	a_hdr_to_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_kind_q == lpcd_pkg::KIND_HEADER && !res_last_q)
		|-> (phase_q == lpcd_pkg::PH_DATA))
		else $error("nonempty header did not enter data phase");

	// A closing record always returns the parser to expect a command
	a_last_to_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_last_q) |-> (phase_q == lpcd_pkg::PH_CMD))
		else $error("frame end did not return to command phase");

	// In the data phase at least one payload byte is still owed
	a_remain_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lpcd_pkg::PH_DATA) |-> (remain_q != '0))
		else $error("data phase with nothing remaining");

	// Header records carry a zero payload byte
	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_kind_q == lpcd_pkg::KIND_HEADER) |-> (res_payload_q == '0))
		else $error("header record with nonzero payload byte");

	// A stalled result is not overwritten by a new byte
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !record.ready) |=> (res_valid_q && $stable(res_length_q)
		&& $stable(res_kind_q) && $stable(phase_q)))
		else $error("result or parser moved during stall");

endmodule

// ===== dv/length_prefixed_command_deframer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_command_deframer_test: self-checking bench for the deframer
// Feeds frames (command, 32-bit big-endian length, payload) with bursty input
// and a stalling record sink. A scoreboard predicts every header and payload
// record and checks each one at the output handshake.
// ----------------------------------------------------------------------------
module length_prefixed_command_deframer_test;

	typedef logic [lpcd_pkg::BYTE_W-1:0] stream_byte_t;
	typedef logic [lpcd_pkg::LEN_W-1:0]  length_t;

	typedef struct packed {
		logic         kind;
		stream_byte_t cmd;
		length_t      len;
		stream_byte_t data;
		logic         last;
	} record_t;

	// Frame tracker and queue of records still owed by the block
	class record_scoreboard;
		lpcd_pkg::phase_t phase;
		stream_byte_t     cmd;
		length_t          len;
		length_t          count;
		record_t          expected_q[$];
		int               errors;

		function new();
			phase  = lpcd_pkg::PH_CMD;
			cmd    = '0;
			len    = '0;
			count  = '0;
			errors = 0;
		endfunction

		function void push_record(logic kind, stream_byte_t data, logic last);
			record_t r;
			r.kind = kind;
			r.cmd  = cmd;
			r.len  = len;
			r.data = data;
			r.last = last;
			expected_q.push_back(r);
		endfunction

		// Step the frame parser on one accepted stream word
		function void note_byte(stream_byte_t b);
			logic last;
			case (phase)
				lpcd_pkg::PH_LEN1: begin
					len   = len | {b, 24'h0};
					phase = lpcd_pkg::PH_LEN2;
				end
				lpcd_pkg::PH_LEN2: begin
					len   = len | {8'h0, b, 16'h0};
					phase = lpcd_pkg::PH_LEN3;
				end
				lpcd_pkg::PH_LEN3: begin
					len   = len | {16'h0, b, 8'h0};
					phase = lpcd_pkg::PH_LEN4;
				end
				lpcd_pkg::PH_LEN4: begin
					len   = len | {24'h0, b};
					count = '0;
					if (len == '0) begin
						// empty frame: header closes it
						phase = lpcd_pkg::PH_CMD;
						push_record(lpcd_pkg::KIND_HEADER, '0, 1'b1);
					end else begin
						phase = lpcd_pkg::PH_DATA;
						push_record(lpcd_pkg::KIND_HEADER, '0, 1'b0);
					end
				end
				lpcd_pkg::PH_DATA: begin
					count = count + 1;
					last  = (count == len);
					push_record(lpcd_pkg::KIND_PAYLOAD, b, last);
					if (last) begin
						phase = lpcd_pkg::PH_CMD;
						count = '0;
					end
				end
				default: begin
					cmd   = b;
					len   = '0;
					count = '0;
					phase = lpcd_pkg::PH_LEN1;
				end
			endcase
		endfunction

		// Compare one output record against the oldest prediction
		function void check_record(record_t got);
			record_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected record kind=%0b cmd=%h len=%h data=%h last=%0b",
					$time, got.kind, got.cmd, got.len, got.data, got.last);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind) begin
				$display("%0t: record_kind expected %0b actual %0b", $time, want.kind, got.kind);
				errors++;
			end
			if (got.cmd !== want.cmd) begin
				$display("%0t: command_code expected %h actual %h", $time, want.cmd, got.cmd);
				errors++;
			end
			if (got.len !== want.len) begin
				$display("%0t: frame_length expected %h actual %h", $time, want.len, got.len);
				errors++;
			end
			if (got.data !== want.data) begin
				$display("%0t: payload_byte expected %h actual %h", $time, want.data, got.data);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: frame_last expected %0b actual %0b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lpcd_byte_if   stream_if ();
	lpcd_record_if record_if ();

	length_prefixed_command_deframer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.record (record_if)
	);

	record_scoreboard sb;
	int   words_sent;
	int   burst_left;
	logic no_gaps;
	logic hold_req;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Output monitor: records checked at the accepting edge
	always @(posedge clk) begin : monitor
		record_t got;
		if (arst_n && record_if.valid === 1'b1 && record_if.ready === 1'b1) begin
			got.kind = record_if.record_kind;
			got.cmd  = record_if.command_code;
			got.len  = record_if.frame_length;
			got.data = record_if.payload_byte;
			got.last = record_if.frame_last;
			sb.check_record(got);
		end
	end

	// Record sink: changing stall patterns, plus one long hold-off on request
	initial begin : receiver
		int   mode;
		int   span;
		int   stall_left;
		logic held;
		record_if.ready = 1'b0;
		stall_left      = 0;
		held            = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				if (hold_req && !held) begin
					record_if.ready = 1'b0;
					repeat (300) @(negedge clk);
					held = 1'b1;
				end else begin
					case (mode)
						0: record_if.ready = 1'b1;
						1: record_if.ready = ($urandom_range(0, 1) == 1);
						2: record_if.ready = ($urandom_range(0, 3) == 0);
						default: begin
							if (stall_left > 0) begin
								record_if.ready = 1'b0;
								stall_left--;
							end else if ($urandom_range(0, 30) == 0) begin
								record_if.ready = 1'b0;
								stall_left = $urandom_range(5, 25);
							end else begin
								record_if.ready = 1'b1;
							end
						end
					endcase
				end
			end
		end
	end

	// Offer one word, with bursts and gaps, and wait for its acceptance
	task automatic send_byte(input stream_byte_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (no_gaps)
				gap = 0;
			else if ($urandom_range(0, 3) == 0)
				gap = $urandom_range(5, 30);
			else
				gap = $urandom_range(0, 4);
			if (gap > 0) begin
				@(negedge clk);
				stream_if.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		stream_if.valid       = 1'b1;
		stream_if.stream_byte = b;
		do @(posedge clk); while (stream_if.ready !== 1'b1);
		sb.note_byte(b);
		words_sent++;
	endtask

	task automatic send_header(input stream_byte_t cmd, input length_t len);
		send_byte(cmd);
		send_byte(len[31:24]);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	task automatic send_random_payload(input int n);
		for (int i = 0; i < n; i++)
			send_byte(stream_byte_t'($urandom_range(0, 255)));
	endtask

	// Withdraw the offered word, then wait for every owed record
	task automatic wait_drained();
		@(negedge clk);
		stream_if.valid = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int      pick;
		int      waited;
		length_t len;
		logic    hold_done;
		logic    pause_done;

		sb                    = new();
		arst_n                = 1'b0;
		clk                   = 1'b0;
		stream_if.valid       = 1'b0;
		stream_if.stream_byte = '0;
		hold_req              = 1'b0;
		no_gaps               = 1'b0;
		burst_left            = 0;
		words_sent            = 0;
		hold_done             = 1'b0;
		pause_done            = 1'b0;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty frames, one- and two-byte frames, extreme bytes
		send_header(8'h00, 32'h0);
		send_header(8'hFF, 32'h1);
		send_byte(8'hFF);
		send_header(8'h5A, 32'h2);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_header(8'h80, 32'h0);

		// Random well-formed frames, mostly short
		while (words_sent < 1700) begin
			no_gaps = ($urandom_range(0, 5) == 0);
			if (!hold_done && words_sent >= 500) begin
				// sink stalls for a long time while a long frame is offered
				hold_req = 1'b1;
				send_header(stream_byte_t'($urandom_range(0, 255)), 32'd80);
				send_random_payload(80);
				hold_done = 1'b1;
			end else if (!pause_done && words_sent >= 1100) begin
				// input pauses until every owed record has come out
				wait_drained();
				pause_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 10)
				len = 0;
			else if (pick < 90)
				len = $urandom_range(1, 12);
			else if (pick < 97)
				len = $urandom_range(13, 64);
			else
				len = $urandom_range(65, 300);
			send_header(stream_byte_t'($urandom_range(0, 255)), len);
			send_random_payload(len);
		end

		// Closing frame with the largest length, left open
		no_gaps = 1'b0;
		send_header(stream_byte_t'($urandom_range(0, 255)), 32'hFFFF_FFFF);
		send_random_payload(10);

		@(negedge clk);
		stream_if.valid = 1'b0;

		// Drain, then let the pipeline settle
		waited = 0;
		while (sb.expected_q.size() != 0 && waited < 100_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);

		if (sb.expected_q.size() != 0) begin
			$display("%0t: %0d expected records never arrived", $time, sb.expected_q.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lpcd_pkg.sv
hdl/lpcd_byte_if.sv
hdl/lpcd_record_if.sv
hdl/length_prefixed_command_deframer.sv
dv/length_prefixed_command_deframer_test.sv
